/* hdl/cces_pkg.sv */
package cces_pkg;

    // Value formats
    localparam int SW       = 24;            // state width, Q3.20
    localparam int FRAC     = SW - 4;
    localparam int ACC_W    = 36;            // datapath width for intermediates
    localparam int MB_W     = 25;            // multiplier second operand width
    localparam int TANH_DEPTH = 256;
    localparam int TI_W     = $clog2(TANH_DEPTH);
    localparam int FR_W     = FRAC + 3;      // interpolation fraction width

    localparam logic signed [ACC_W-1:0] ONE_Q   = ACC_W'(64'd1 << FRAC);
    localparam logic signed [ACC_W-1:0] UNA_Q   = ACC_W'(((64'd23 << FRAC) + 64'd50) / 64'd100);
    localparam logic signed [ACC_W-1:0] STIM_Q  = ACC_W'(64'd3 << FRAC);
    localparam logic signed [MB_W-1:0]  DT_Q30  = MB_W'(10737418);
    localparam logic [40:0]             INV_CAP = 41'(64'd256 << FRAC);
    localparam longint unsigned         LN2_Q20 = 726817;

    // Rounding shift applied after a product
    typedef enum logic [2:0] {
        SH_12,
        SH_16,
        SH_20,
        SH_23,
        SH_30
    } shift_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] a;
        logic signed [MB_W-1:0]  b;
        shift_t                  sh;
    } mul_in_t;

    typedef logic [SW-1:0] tanh_rom_t [0:TANH_DEPTH];

    // shift-and-subtract quotient, used only while building the table
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned q, r;
        int              j;
        q = 0;
        r = 0;
        for (j = 63; j >= 0; j--) begin
            r = {r[62:0], num[j]};
            if (r >= den) begin
                r = r - den;
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh table built at elaboration: integer exp(-2x) by ln2 reduction and Taylor series
    function automatic tanh_rom_t tanh_build();
        tanh_rom_t       rom;
        longint unsigned z, k, r, term, pos, negs, e, num, den;
        int              i, n;
        for (i = 0; i <= TANH_DEPTH; i++) begin
            z = (longint'(i) << 24) >> TI_W;
            k = udiv(z, LN2_Q20);
            r = (z - k * LN2_Q20) << 10;
            term = 64'd1 << 30;
            pos = term;
            negs = 0;
            for (n = 1; n <= 13; n++) begin
                term = udiv((term * r) >> 30, longint'(n));
                if (n[0]) negs += term;
                else pos += term;
            end
            e = (k >= 40) ? 64'd0 : ((pos - negs) >> k);
            num = (64'd1 << 30) - e;
            den = (64'd1 << 30) + e;
            rom[i] = SW'(udiv((num << FRAC) + (den >> 1), den));
        end
        return rom;
    endfunction

    localparam tanh_rom_t TANH_ROM = tanh_build();

endpackage

/* hdl/cces_mul.sv */
module cces_mul import cces_pkg::*; (
    input  logic                    aclk,
    input  mul_in_t                 op,
    output logic signed [ACC_W-1:0] res
);

    localparam int PW = ACC_W + MB_W;

    logic [ACC_W-1:0] amag;
    logic [MB_W-1:0]  bmag;
    logic [PW-1:0]    prod_reg;
    logic             neg_reg;
    shift_t           sh_reg;
    logic [4:0]       shamt;
    logic [PW:0]      rnd;
    logic [PW:0]      quo;

    // sign-magnitude operands
    always_comb begin
        amag = op.a[ACC_W-1] ? ACC_W'(-op.a) : ACC_W'(op.a);
        bmag = op.b[MB_W-1]  ? MB_W'(-op.b)  : MB_W'(op.b);
    end

    // stage 1: unsigned product
    always_ff @(posedge aclk) begin
        prod_reg <= amag * bmag;
        neg_reg  <= op.a[ACC_W-1] ^ op.b[MB_W-1];
        sh_reg   <= op.sh;
    end

    // stage 2: round to nearest, ties away from zero, then restore sign
    always_comb begin
        unique case (sh_reg)
            SH_12:   shamt = 5'd12;
            SH_16:   shamt = 5'd16;
            SH_20:   shamt = 5'd20;
            SH_23:   shamt = 5'd23;
            SH_30:   shamt = 5'd30;
            default: shamt = 5'd12;
        endcase
        rnd = {1'b0, prod_reg} + ((PW+1)'(1) << (shamt - 5'd1));
        quo = rnd >> shamt;
    end

    always_ff @(posedge aclk) begin
        res <= neg_reg ? -ACC_W'(quo) : ACC_W'(quo);
    end

endmodule

/* hdl/cardiac_cell_euler_step.sv */
// Four-variable cardiac cell, one forward-Euler step per input item.
// Input channel s_*: one item per tick; s_tdata bit 0 is restart, which returns
// the cell state, tick counters and peak tracking to their initial values first.
// Output channel m_*: one result item per input item, in order.
// Configuration channel cfg_*: index 0..6 selects thresholds, sigmoid settings,
// fast gate rates, slow gate rates, current times, period and stimulus length.
// Always ready; write it only while the block is idle.
// Each tick runs 18 multiplies on one shared two-stage multiplier, a 41-step
// restoring divider for 1/tso plus a final step to cap the quotient (only the
// capping step when tso is not positive), and an accept state and an output
// load state. s_tready is high only while idle.
// The result sits in an output register; a stalled receiver holds it, and the
// next item may be accepted meanwhile, but its result waits for the register.
// Reset (aresetn low, synchronous) restores register defaults (period 40000,
// stimulus 300, others 0) and the initial cell state.
module cardiac_cell_euler_step import cces_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [0] restart
    output logic         m_tvalid,
    input  logic         m_tready,
    // [23:0] membrane_voltage, [47:24] fast_gate, [71:48] slow_gate,
    // [95:72] d_gate, [96] stimulus_on, [112:97] beat_count,
    // [136:113] peak_voltage, [168:137] peak_tick
    output logic [175:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} state_t;

    typedef enum logic [4:0] {
        K_TSO_ARG, K_TSO_TANH, K_TSO, K_DV, K_DW, K_D_ARG, K_D_TANH, K_DD,
        K_V, K_W, K_D, K_FI1, K_FI2, K_FI3, K_SO, K_SI1, K_SI2, K_U
    } step_t;

    typedef enum logic [2:0] {
        CFG_THRESH, CFG_SIGMOID, CFG_FAST, CFG_SLOW, CFG_CURRENT, CFG_PERIOD, CFG_STIM
    } cfg_idx_t;

    // configuration
    logic [63:0] thr_reg, sig_reg, fast_reg, slow_reg, cur_reg;
    logic [19:0] period_reg;
    logic [15:0] stim_ticks_reg;

    // control
    state_t      state_reg;
    step_t       step_reg;
    logic [1:0]  phase_reg;
    logic        m_tvalid_reg;
    logic [175:0] m_tdata_reg;

    // cell state and bookkeeping
    logic signed [SW-1:0] u_reg, v_reg, w_reg, d_reg;
    logic signed [SW-1:0] vn_reg, wn_reg, dn_reg;
    logic [31:0]          tick_reg, peak_idx_reg;
    logic [19:0]          pos_reg;
    logic [15:0]          beats_reg;
    logic signed [SW-1:0] peak_reg;
    logic                 stim_reg;

    // intermediates
    logic signed [ACC_W-1:0] tmp_reg, dv_reg, dw_reg, dd_reg, xfi_reg, xso_reg, xsi_reg;
    logic signed [21:0]      half_reg;

    // divider
    logic [40:0] div_num_reg, div_q_reg;
    logic [29:0] div_den_reg, div_rem_reg;
    logic [5:0]  div_cnt_reg;
    logic [30:0] div_sh, div_sub;
    logic        div_ge;

    mul_in_t                 mul_in;
    logic signed [ACC_W-1:0] mul_res;

    cces_mul u_mul (
        .aclk (aclk),
        .op   (mul_in),
        .res  (mul_res)
    );

    // register fields
    logic signed [SW-1:0]    uc, uv, uw, ud, ucsi, uso;
    logic [15:0]             xk, xtso;
    logic signed [ACC_W-1:0] tsoa, tsob;
    logic signed [ACC_W-1:0] u36, v36, w36, d36;
    always_comb begin
        uc   = {thr_reg[15:0], 8'b0};
        uv   = {thr_reg[31:16], 8'b0};
        uw   = {thr_reg[47:32], 8'b0};
        ud   = {thr_reg[63:48], 8'b0};
        ucsi = {sig_reg[15:0], 8'b0};
        xk   = sig_reg[31:16];
        uso  = {sig_reg[47:32], 8'b0};
        xtso = sig_reg[63:48];
        tsoa = ACC_W'({cur_reg[15:0], 12'b0});
        tsob = ACC_W'({cur_reg[31:16], 12'b0});
        u36  = ACC_W'(u_reg);
        v36  = ACC_W'(v_reg);
        w36  = ACC_W'(w_reg);
        d36  = ACC_W'(d_reg);
    end

    logic u_hi;
    assign u_hi = (u36 > UNA_Q);

    // tanh table lookup from the argument in tmp_reg
    logic [ACC_W-1:0]        tmag;
    logic                    tbig;
    logic [TI_W-1:0]         ti;
    logic [FR_W-1:0]         tfr;
    logic [SW-1:0]           rom_lo, rom_hi;
    logic signed [ACC_W-1:0] tdiff, ty, th, hsum;
    logic signed [21:0]      half_val;
    always_comb begin
        tmag   = tmp_reg[ACC_W-1] ? ACC_W'(-tmp_reg) : ACC_W'(tmp_reg);
        tbig   = |tmag[ACC_W-1:FR_W];
        ti     = tmag[FR_W-1 -: TI_W];
        tfr    = {tmag[FR_W-TI_W-1:0], TI_W'(0)};
        rom_lo = TANH_ROM[{1'b0, ti}];
        rom_hi = TANH_ROM[(TI_W+1)'(ti) + (TI_W+1)'(1)];
        tdiff  = ACC_W'(rom_hi) - ACC_W'(rom_lo);
        ty     = tbig ? ACC_W'(TANH_ROM[TANH_DEPTH]) : ACC_W'(rom_lo) + mul_res;
        th     = tmp_reg[ACC_W-1] ? -ty : ty;
        hsum   = ONE_Q + th;
        half_val = 22'(hsum >>> 1);
    end

    // stimulus and period position
    logic                    stim_now, last;
    logic [19:0]             per_m1;
    logic signed [ACC_W-1:0] du;
    always_comb begin
        stim_now = (pos_reg <= 20'(stim_ticks_reg));
        per_m1   = (period_reg == 20'd0) ? 20'd0 : period_reg - 20'd1;
        last     = (pos_reg >= per_m1);
        du       = (stim_now ? STIM_Q : ACC_W'(0)) - xfi_reg - xso_reg - xsi_reg;
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_in.a  = '0;
        mul_in.b  = '0;
        mul_in.sh = SH_12;
        unique case (step_reg)
            K_TSO_ARG: begin
                mul_in.a = u36 - ACC_W'(uso);
                mul_in.b = MB_W'(xtso);
            end
            K_TSO_TANH, K_D_TANH: begin
                mul_in.a  = tdiff;
                mul_in.b  = MB_W'(tfr);
                mul_in.sh = SH_23;
            end
            K_TSO: begin
                mul_in.a  = tsob - tsoa;
                mul_in.b  = MB_W'(half_reg);
                mul_in.sh = SH_20;
            end
            K_DV: begin
                mul_in.a  = u_hi ? v36 : ONE_Q - v36;
                mul_in.b  = u_hi ? MB_W'(fast_reg[47:32])
                          : (u_reg > uv ? MB_W'(fast_reg[31:16]) : MB_W'(fast_reg[15:0]));
                mul_in.sh = SH_16;
            end
            K_DW: begin
                mul_in.a  = (u_reg > uw) ? w36 : ONE_Q - w36;
                mul_in.b  = (u_reg > uw) ? MB_W'(slow_reg[31:16]) : MB_W'(slow_reg[15:0]);
                mul_in.sh = SH_16;
            end
            K_D_ARG: begin
                mul_in.a = u36 - ACC_W'(ucsi);
                mul_in.b = MB_W'(xk);
            end
            K_DD: begin
                mul_in.a  = ACC_W'(half_reg) - d36;
                mul_in.b  = (u_reg > ud) ? MB_W'(slow_reg[47:32]) : MB_W'(slow_reg[63:48]);
                mul_in.sh = SH_16;
            end
            K_V: begin
                mul_in.a  = dv_reg;
                mul_in.b  = DT_Q30;
                mul_in.sh = SH_30;
            end
            K_W: begin
                mul_in.a  = dw_reg;
                mul_in.b  = DT_Q30;
                mul_in.sh = SH_30;
            end
            K_D: begin
                mul_in.a  = dd_reg;
                mul_in.b  = DT_Q30;
                mul_in.sh = SH_30;
            end
            K_FI1: begin
                mul_in.a  = u36 - UNA_Q;
                mul_in.b  = MB_W'(ONE_Q - u36);
                mul_in.sh = SH_20;
            end
            K_FI2: begin
                mul_in.a  = tmp_reg;
                mul_in.b  = MB_W'(vn_reg);
                mul_in.sh = SH_20;
            end
            K_FI3: begin
                mul_in.a  = tmp_reg;
                mul_in.b  = MB_W'(fast_reg[63:48]);
                mul_in.sh = SH_16;
            end
            K_SO: begin
                mul_in.a  = u36;
                mul_in.b  = MB_W'(cur_reg[47:32]);
                mul_in.sh = SH_16;
            end
            K_SI1: begin
                mul_in.a  = ACC_W'(wn_reg);
                mul_in.b  = MB_W'(dn_reg);
                mul_in.sh = SH_20;
            end
            K_SI2: begin
                mul_in.a  = tmp_reg;
                mul_in.b  = MB_W'(cur_reg[63:48]);
                mul_in.sh = SH_16;
            end
            K_U: begin
                mul_in.a  = du;
                mul_in.b  = DT_Q30;
                mul_in.sh = SH_30;
            end
            default: ;
        endcase
    end

    // saturate a sum to the state range
    function automatic logic signed [SW-1:0] sat_st(input logic signed [ACC_W:0] x);
        if (&x[ACC_W:SW-1] || ~|x[ACC_W:SW-1]) return x[SW-1:0];
        else if (x[ACC_W]) return {1'b1, {(SW-1){1'b0}}};
        else return {1'b0, {(SW-1){1'b1}}};
    endfunction

    logic signed [ACC_W:0]   sum_v, sum_w, sum_d, sum_u;
    logic signed [SW-1:0]    un, peak_base;
    logic signed [ACC_W-1:0] tso_v;
    always_comb begin
        sum_v = (ACC_W+1)'(v_reg) + (ACC_W+1)'(mul_res);
        sum_w = (ACC_W+1)'(w_reg) + (ACC_W+1)'(mul_res);
        sum_d = (ACC_W+1)'(d_reg) + (ACC_W+1)'(mul_res);
        sum_u = (ACC_W+1)'(u_reg) + (ACC_W+1)'(mul_res);
        un    = sat_st(sum_u);
        peak_base = last ? SW'(-ONE_Q) : peak_reg;
        tso_v = tsoa + mul_res;
    end

    // one restoring divider step
    always_comb begin
        div_sh  = {div_rem_reg, div_num_reg[40]};
        div_ge  = (div_sh >= {1'b0, div_den_reg});
        div_sub = div_sh - {1'b0, div_den_reg};
    end

    // sequencer, state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg        <= '0;
            sig_reg        <= '0;
            fast_reg       <= '0;
            slow_reg       <= '0;
            cur_reg        <= '0;
            period_reg     <= 20'd40000;
            stim_ticks_reg <= 16'd300;
            state_reg      <= ST_IDLE;
            step_reg       <= K_TSO_ARG;
            phase_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            div_cnt_reg    <= '0;
            u_reg          <= '0;
            v_reg          <= SW'(ONE_Q);
            w_reg          <= SW'(ONE_Q);
            d_reg          <= '0;
            tick_reg       <= '0;
            pos_reg        <= '0;
            beats_reg      <= '0;
            peak_reg       <= {1'b1, {(SW-1){1'b0}}};
            peak_idx_reg   <= '0;
        end else begin
            // configuration writes
            if (cfg_valid) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_THRESH:  thr_reg        <= cfg_data;
                    CFG_SIGMOID: sig_reg        <= cfg_data;
                    CFG_FAST:    fast_reg       <= cfg_data;
                    CFG_SLOW:    slow_reg       <= cfg_data;
                    CFG_CURRENT: cur_reg        <= cfg_data;
                    CFG_PERIOD:  period_reg     <= cfg_data[19:0];
                    CFG_STIM:    stim_ticks_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end

            // the done state reloads the output register itself
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tdata[0]) begin
                            u_reg        <= '0;
                            v_reg        <= SW'(ONE_Q);
                            w_reg        <= SW'(ONE_Q);
                            d_reg        <= '0;
                            tick_reg     <= '0;
                            pos_reg      <= '0;
                            beats_reg    <= '0;
                            peak_reg     <= {1'b1, {(SW-1){1'b0}}};
                            peak_idx_reg <= '0;
                        end
                        step_reg  <= K_TSO_ARG;
                        phase_reg <= '0;
                        state_reg <= ST_MUL;
                    end
                end

                ST_MUL: begin
                    if (phase_reg != 2'd2) begin
                        phase_reg <= phase_reg + 2'd1;
                    end else begin
                        phase_reg <= '0;
                        step_reg  <= step_t'(step_reg + 5'd1);
                        unique case (step_reg)
                            K_TSO_ARG, K_D_ARG: tmp_reg <= mul_res;
                            K_TSO_TANH, K_D_TANH: half_reg <= half_val;
                            K_TSO: begin
                                if (tso_v > 0) begin
                                    div_den_reg <= tso_v[29:0];
                                    div_num_reg <= (41'(1) << 40) + 41'(tso_v[29:1]);
                                    div_rem_reg <= '0;
                                    div_q_reg   <= '0;
                                    div_cnt_reg <= 6'd41;
                                    state_reg   <= ST_DIV;
                                end else begin
                                    div_q_reg   <= INV_CAP;
                                    div_cnt_reg <= '0;
                                    state_reg   <= ST_DIV;
                                end
                            end
                            K_DV:  dv_reg <= u_hi ? -mul_res : mul_res;
                            K_DW:  dw_reg <= (u_reg > uw) ? -mul_res : mul_res;
                            K_DD:  dd_reg <= mul_res;
                            K_V:   vn_reg <= sat_st(sum_v);
                            K_W:   wn_reg <= sat_st(sum_w);
                            K_D:   dn_reg <= sat_st(sum_d);
                            K_FI1, K_FI2, K_SI1: tmp_reg <= mul_res;
                            K_FI3: xfi_reg <= u_hi ? -mul_res : ACC_W'(0);
                            K_SO:  xso_reg <= (u_reg > uc) ? xso_reg : mul_res;
                            K_SI2: xsi_reg <= -mul_res;
                            K_U: begin
                                u_reg    <= un;
                                v_reg    <= vn_reg;
                                w_reg    <= wn_reg;
                                d_reg    <= dn_reg;
                                stim_reg <= stim_now;
                                if (pos_reg == 20'd0 && beats_reg != 16'hFFFF)
                                    beats_reg <= beats_reg + 16'd1;
                                if (un > peak_base) begin
                                    peak_reg     <= un;
                                    peak_idx_reg <= tick_reg;
                                end else begin
                                    peak_reg <= peak_base;
                                end
                                pos_reg   <= last ? 20'd0 : pos_reg + 20'd1;
                                tick_reg  <= tick_reg + 32'd1;
                                state_reg <= ST_DONE;
                            end
                            default: ;
                        endcase
                    end
                end

                ST_DIV: begin
                    if (div_cnt_reg == '0) begin
                        // capped reciprocal; also the current used above threshold
                        xso_reg   <= ACC_W'((div_q_reg > INV_CAP) ? INV_CAP : div_q_reg);
                        step_reg  <= K_DV;
                        phase_reg <= '0;
                        state_reg <= ST_MUL;
                    end else begin
                        div_rem_reg <= div_ge ? div_sub[29:0] : div_sh[29:0];
                        div_q_reg   <= {div_q_reg[39:0], div_ge};
                        div_num_reg <= {div_num_reg[39:0], 1'b0};
                        div_cnt_reg <= div_cnt_reg - 6'd1;
                    end
                end

                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {7'b0, peak_idx_reg, peak_reg, beats_reg, stim_reg,
                                         d_reg, w_reg, v_reg, u_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    // an accepted item makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // a result appears only out of the done state
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    // divider count never exceeds the quotient length
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> div_cnt_reg <= 6'd41)
        else $error("divider count out of range");

endmodule

/* tb/sv/tb_cardiac_cell_euler_step.sv */
`timescale 1ns / 1ps

// Bit-exact model of the cell step plus an in-order store of expected results
class cell_scoreboard;
    localparam int FB = 20;
    localparam longint ONE = longint'(1) << FB;
    localparam longint UNA = ((longint'(23) << FB) + 50) / 100;
    localparam longint STIM_I = longint'(3) << FB;
    localparam longint DT30 = 10737418;
    localparam longint CAP = longint'(256) << FB;
    localparam longint SMAX = (longint'(1) << 23) - 1;
    localparam longint SMIN = -(longint'(1) << 23);
    localparam longint unsigned LN2 = 726817;
    localparam int TDEPTH = 256;

    longint tanh_tab [0:TDEPTH];
    logic [63:0] regs [0:6];
    longint u_st, v_st, w_st, d_st, pk_lvl;
    int unsigned ticks, tpos, beats_n, pk_idx;
    logic [168:0] expected_q [$];
    int fails;

    function new();
        longint unsigned z, k, r, term, pos, negs, e, num, den;
        int i, n;
        for (i = 0; i <= TDEPTH; i++) begin
            z = (longint'(i) << 24) / TDEPTH;
            k = z / LN2;
            r = (z - k * LN2) << 10;
            term = 64'd1 << 30;
            pos = term;
            negs = 0;
            for (n = 1; n <= 13; n++) begin
                term = ((term * r) >> 30) / n;
                if (n % 2 == 1) negs += term;
                else pos += term;
            end
            e = (k >= 40) ? 0 : ((pos - negs) >> k);
            num = (64'd1 << 30) - e;
            den = (64'd1 << 30) + e;
            tanh_tab[i] = longint'(((num << FB) + den / 2) / den);
        end
        regs[0] = 0; regs[1] = 0; regs[2] = 0; regs[3] = 0; regs[4] = 0;
        regs[5] = 40000;
        regs[6] = 300;
        fails = 0;
        init_state();
    endfunction

    function void init_state();
        u_st = 0; v_st = ONE; w_st = ONE; d_st = 0;
        ticks = 0; tpos = 0; beats_n = 0; pk_lvl = SMIN; pk_idx = 0;
    endfunction

    function void write_reg(int idx, logic [63:0] val);
        if (idx == 5) regs[idx] = val & 64'hFFFFF;
        else if (idx == 6) regs[idx] = val & 64'hFFFF;
        else regs[idx] = val;
    endfunction

    function longint fs(int idx, int k);
        return longint'(signed'(regs[idx][16*k +: 16]));
    endfunction

    function longint fu(int idx, int k);
        return longint'({48'd0, regs[idx][16*k +: 16]});
    endfunction

    // rounded product, ties away from zero, magnitude capped at 2^60
    function longint mulr(longint a, longint b, int s);
        logic [127:0] p;
        longint unsigned ua, ub;
        longint res;
        bit neg;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        p = {64'd0, ua} * {64'd0, ub};
        p = (p + (128'd1 << (s - 1))) >> s;
        if (p > (128'd1 << 60)) p = 128'd1 << 60;
        res = longint'(p[63:0]);
        return neg ? -res : res;
    endfunction

    function longint sat(longint x);
        return x > SMAX ? SMAX : (x < SMIN ? SMIN : x);
    endfunction

    function longint tanh_fx(longint x);
        longint unsigned mag, p, i, fr;
        longint y;
        mag = x < 0 ? -x : x;
        if (mag >= (longint'(8) << FB)) begin
            y = tanh_tab[TDEPTH];
        end else begin
            p = mag * TDEPTH;
            i = p >> (FB + 3);
            fr = p & ((64'd1 << (FB + 3)) - 1);
            y = tanh_tab[i] + mulr(tanh_tab[i+1] - tanh_tab[i], longint'(fr), FB + 3);
        end
        return x < 0 ? -y : y;
    endfunction

    // advance the cell by one tick for an accepted input item
    function void note(bit restart);
        longint uc, uv, uw, ud, ucsi, xk, uso, xtso, tsoa, tsob;
        longint u, v, w, d, half, tso, inv_tso, rate, dv, dw, dd, target;
        longint xfi, xso, xsi, du, stim_cur;
        int unsigned per, pos;
        bit stim, last;
        if (restart) init_state();
        uc = fs(0, 0) << 8; uv = fs(0, 1) << 8; uw = fs(0, 2) << 8; ud = fs(0, 3) << 8;
        ucsi = fs(1, 0) << 8; xk = fu(1, 1); uso = fs(1, 2) << 8; xtso = fu(1, 3);
        tsoa = fu(4, 0) << 12; tsob = fu(4, 1) << 12;

        per = regs[5] == 0 ? 1 : int'(regs[5]);
        pos = tpos;
        if (pos == 0 && beats_n < 16'hFFFF) beats_n++;
        stim = pos <= regs[6];
        stim_cur = stim ? STIM_I : 0;
        u = u_st; v = v_st; w = w_st; d = d_st;

        half = (ONE + tanh_fx(mulr(u - uso, xtso, 12))) / 2;
        if (half < 0) half = 0;
        tso = tsoa + mulr(tsob - tsoa, half, FB);
        if (tso <= 0) inv_tso = CAP;
        else begin
            inv_tso = ((longint'(1) << (2 * FB)) + tso / 2) / tso;
            if (inv_tso > CAP) inv_tso = CAP;
        end

        if (u > UNA) dv = -mulr(v, fu(2, 2), 16);
        else begin
            rate = u > uv ? fu(2, 1) : fu(2, 0);
            dv = mulr(ONE - v, rate, 16);
        end
        if (u > uw) dw = -mulr(w, fu(3, 1), 16);
        else dw = mulr(ONE - w, fu(3, 0), 16);
        target = (ONE + tanh_fx(mulr(u - ucsi, xk, 12))) / 2;
        rate = u > ud ? fu(3, 2) : fu(3, 3);
        dd = mulr(target - d, rate, 16);

        v = sat(v + mulr(dv, DT30, 30));
        w = sat(w + mulr(dw, DT30, 30));
        d = sat(d + mulr(dd, DT30, 30));

        xfi = 0;
        if (u > UNA)
            xfi = -mulr(mulr(mulr(u - UNA, ONE - u, FB), v, FB), fu(2, 3), 16);
        xso = u > uc ? inv_tso : mulr(u, fu(4, 2), 16);
        xsi = -mulr(mulr(w, d, FB), fu(4, 3), 16);
        du = stim_cur - xfi - xso - xsi;
        u = sat(u + mulr(du, DT30, 30));
        u_st = u; v_st = v; w_st = w; d_st = d;

        // peak restarts at -1.0 on the last tick of a period
        last = pos >= per - 1;
        if (last) pk_lvl = -ONE;
        if (u > pk_lvl) begin
            pk_lvl = u;
            pk_idx = ticks;
        end
        tpos = last ? 0 : pos + 1;
        ticks = ticks + 1;

        expected_q.push_back({pk_idx, pk_lvl[23:0], beats_n[15:0], stim,
                              d[23:0], w[23:0], v[23:0], u[23:0]});
    endfunction

    function void check(logic [175:0] got);
        string names [8] = '{"membrane_voltage", "fast_gate", "slow_gate", "d_gate",
                             "stimulus_on", "beat_count", "peak_voltage", "peak_tick"};
        int lo [8] = '{0, 24, 48, 72, 96, 97, 113, 137};
        int wd [8] = '{24, 24, 24, 24, 1, 16, 24, 32};
        logic [168:0] want;
        logic [31:0] ev, av;
        int f;
        if (expected_q.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected result item: %h", got);
            return;
        end
        want = expected_q.pop_front();
        for (f = 0; f < 8; f++) begin
            ev = (want >> lo[f]) & ((33'd1 << wd[f]) - 1);
            av = (got >> lo[f]) & ((33'd1 << wd[f]) - 1);
            if (ev !== av) begin
                fails++;
                if (fails <= 10) $display("mismatch %s: expected %h, got %h", names[f], ev, av);
            end
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_cardiac_cell_euler_step;
    import cces_pkg::*;

    localparam int REG_THRESH = 0;
    localparam int REG_SIGMOID = 1;
    localparam int REG_FAST = 2;
    localparam int REG_SLOW = 3;
    localparam int REG_CURRENT = 4;
    localparam int REG_PERIOD = 5;
    localparam int REG_STIM = 6;
    localparam int SETTLE_CYCLES = 150;
    localparam int PHASE_ITEMS = 283;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [175:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_data;

    int tx_idle, rx_idle;
    cell_scoreboard sb;
    logic [63:0] cfg_set [0:6];

    cardiac_cell_euler_step dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // receiver stalls
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check(m_tdata);
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // one tick item; entered and left at a falling edge
    task automatic send_tick(bit restart);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, restart};
        do @(posedge aclk); while (!s_tready);
        sb.note(restart);
        @(negedge aclk);
    endtask

    task automatic write_all();
        int i;
        for (i = REG_THRESH; i <= REG_STIM; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data <= cfg_set[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.write_reg(i, cfg_set[i]);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // plausible model parameters with random jitter and a short pacing period
    task automatic pick_physio(int unsigned per, int unsigned stim_len);
        cfg_set[REG_THRESH] = {16'd200 + 16'($urandom_range(200)), 16'd532,
                               16'd164 + 16'($urandom_range(100)), 16'd532};
        cfg_set[REG_SIGMOID] = {16'd8000 + 16'($urandom_range(4000)), 16'd2600,
                                16'd40960, 16'd3482};
        cfg_set[REG_FAST] = {16'hFFFF, 16'd45197, 16'd57, 16'd1092 + 16'($urandom_range(500))};
        cfg_set[REG_SLOW] = {16'd6554, 16'd26214, 16'd328, 16'd1092};
        cfg_set[REG_CURRENT] = {16'd34493, 16'd10923 + 16'($urandom_range(3000)),
                                16'd5120, 16'd7680};
        cfg_set[REG_PERIOD] = per;
        cfg_set[REG_STIM] = stim_len;
    endtask

    initial begin
        int ph, n, sel;
        sb = new();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        m_tready = 0;
        cfg_valid = 0;
        cfg_index = 0;
        cfg_data = 0;
        tx_idle = 28;
        rx_idle = 45;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // defaults: all rates zero, so tso is zero and 1/tso saturates
        send_tick(0);
        send_tick(0);
        send_tick(1);

        // plausible cell, short period, restart mid-run
        drain();
        pick_physio(7, 2);
        write_all();
        for (n = 0; n < 12; n++) send_tick(n == 9);

        // all registers at their maximum
        drain();
        foreach (cfg_set[i]) cfg_set[i] = '1;
        write_all();
        for (n = 0; n < 4; n++) send_tick(0);

        // all zero: period zero acts as one, so every tick is at position zero and gets the stimulus
        drain();
        foreach (cfg_set[i]) cfg_set[i] = '0;
        write_all();
        for (n = 0; n < 4; n++) send_tick(n == 3);

        for (ph = 0; ph < 3; ph++) begin
            tx_idle = (ph == 0) ? 28 : (ph == 1) ? 45 : 0;
            rx_idle = (ph == 0) ? 45 : (ph == 1) ? 28 : 0;
            drain();
            sel = $urandom_range(9);
            if (ph == 1 || sel == 0) begin
                // raw random registers, some fields saturate
                foreach (cfg_set[i]) cfg_set[i] = {$urandom, $urandom};
            end else begin
                pick_physio($urandom_range(2, 60), $urandom_range(0, 12));
            end
            if (ph == 2) begin
                cfg_set[REG_PERIOD] = 20'hFFFFF;
                cfg_set[REG_STIM] = 16'hFFFF;
            end
            write_all();
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 0 && n == PHASE_ITEMS / 2) drain();
                // shrinking the period mid-run makes the tick overrun the period
                if (ph == 0 && n == 200) begin
                    drain();
                    cfg_set[REG_PERIOD] = 3;
                    write_all();
                end
                send_tick($urandom_range(99) < 3);
            end
        end

        drain();
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

/* files.f */
hdl/cces_pkg.sv
hdl/cces_mul.sv
hdl/cardiac_cell_euler_step.sv
tb/sv/tb_cardiac_cell_euler_step.sv
